>>> hdl/vc_pkg.sv
// vc_pkg: shared types and constants of the varint codec
// used by vc_dec and varint_codec; no dependencies
package vc_pkg;

	// 7-bit groups, at most ten of them for a 64-bit value
	localparam int unsigned GROUP_W  = 7;
	localparam int unsigned VALUE_W  = 64;
	localparam int unsigned NARROW_W = 32;
	localparam int unsigned ACC_W    = 70;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned CNT_W    = 4;

	localparam logic [CNT_W-1:0] GROUPS_MAX   = 4'd10;
	localparam logic [CNT_W-1:0] LIMIT_NARROW = 4'd5;
	localparam logic [CNT_W-1:0] LIMIT_WIDE   = 4'd10;

	// command and result kind codes
	localparam logic CMD_ENCODE = 1'b0;
	localparam logic CMD_DECODE = 1'b1;
	localparam logic KIND_BYTE  = 1'b0;
	localparam logic KIND_VALUE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ENC,
		ST_ERR,
		ST_ALIGN
	} state_t;

	// control from the sequencer to the decode accumulator
	typedef struct packed {
		logic take;
		logic align;
		logic clear;
	} dec_ctrl_t;

	// status back from the decode accumulator
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             done;
	} dec_stat_t;

endpackage

>>> hdl/varint_codec.sv
// varint_codec: unsigned LEB128 varint encoder and streaming decoder, top level
// instantiates vc_dec; uses vc_pkg
// Usage:
//   slave channel s_*: one word per command; s_tuser is the command (encode or
//   decode), s_tdata carries the value to encode and the byte to decode.
//   master channel m_*: result words; m_tuser says whether the word is an
//   encoded byte or a decoded value and flags a decode over the byte limit,
//   m_tlast marks the final result of a command.
//   cfg channel: one write of cfg_data sets the width mode (0 = 32 bit,
//   1 = 64 bit); always ready, write only while no command is in flight.
// Timing:
//   encode emits one byte per cycle while the result slot is free, n bytes
//   for an n-group value, from a 7-bit digit shift register; the next word
//   is taken after the last byte. a decode byte with continuation set below
//   the byte limit is taken with no result. after a closing decode byte, zero
//   shifts fill the accumulator shift line up to the ten group shifts it needs
//   to align the value; a limit error result is loaded from the error state.
// The result register lets the core go on while a result waits; a stalled
// receiver holds the core only when it has its next result ready.
// Reset clears the mode to 32 bit, the decode state and the result register.
module varint_codec (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,      // wide_mode
	// command stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,       // value[63:0], in_byte[71:64]
	input  logic        s_tuser,       // cmd
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,       // out_byte[7:0], out_value[71:8]
	output logic [1:0]  m_tuser,       // kind[0], error[1]
	output logic        m_tlast        // last
);
	import vc_pkg::*;

	state_t state_q, state_d;

	logic                wide_q;
	logic [VALUE_W-1:0]  enc_q;
	logic                enc_load, enc_shift, enc_more;

	dec_ctrl_t           dec_ctrl;
	dec_stat_t           dec_stat;
	logic [VALUE_W-1:0]  dec_value;

	logic                accept, slot_free, in_more, at_limit;
	logic [CNT_W-1:0]    limit;
	logic [BYTE_W-1:0]   in_byte;

	logic                out_load, out_kind, out_error, out_last;
	logic [BYTE_W-1:0]   out_byte;
	logic [VALUE_W-1:0]  out_value;

	logic                m_tvalid_q;
	logic [71:0]         m_tdata_q;
	logic [1:0]          m_tuser_q;
	logic                m_tlast_q;

	// decode accumulator
	vc_dec u_dec (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (dec_ctrl),
		.group_in  (in_byte[GROUP_W-1:0]),
		.wide_mode (wide_q),
		.stat      (dec_stat),
		.value     (dec_value)
	);

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q <= 1'b0;
		end else if (cfg_valid) begin
			wide_q <= cfg_data;
		end
	end

	// handshake and decode limit
	assign accept    = s_tvalid && s_tready;
	assign slot_free = !m_tvalid_q || m_tready;
	assign in_byte   = s_tdata[71:64];
	assign in_more   = in_byte[BYTE_W-1];
	assign limit     = wide_q ? LIMIT_WIDE : LIMIT_NARROW;
	assign at_limit  = (dec_stat.count + 4'd1) >= limit;
	assign enc_more  = |enc_q[VALUE_W-1:GROUP_W];

	// encode shift register, one group per emitted byte
	always_ff @(posedge clk) begin
		if (enc_load) begin
			enc_q <= wide_q ? s_tdata[VALUE_W-1:0]
			                : {{(VALUE_W-NARROW_W){1'b0}}, s_tdata[NARROW_W-1:0]};
		end else if (enc_shift) begin
			enc_q <= {{GROUP_W{1'b0}}, enc_q[VALUE_W-1:GROUP_W]};
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (s_tuser == CMD_ENCODE) begin
						state_d = ST_ENC;
					end else if (!in_more) begin
						state_d = ST_ALIGN;
					end else if (at_limit) begin
						state_d = ST_ERR;
					end
				end
			end
			ST_ENC: begin
				if (slot_free && !enc_more) state_d = ST_IDLE;
			end
			ST_ERR: begin
				if (slot_free) state_d = ST_IDLE;
			end
			ST_ALIGN: begin
				if (dec_stat.done && slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready       = 1'b0;
		enc_load       = 1'b0;
		enc_shift      = 1'b0;
		dec_ctrl.take  = 1'b0;
		dec_ctrl.align = 1'b0;
		dec_ctrl.clear = 1'b0;
		out_load       = 1'b0;
		out_kind       = KIND_BYTE;
		out_error      = 1'b0;
		out_last       = 1'b0;
		out_byte       = '0;
		out_value      = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (accept) begin
					if (s_tuser == CMD_ENCODE) begin
						enc_load = 1'b1;
					end else if (in_more && at_limit) begin
						dec_ctrl.clear = 1'b1;
					end else begin
						dec_ctrl.take = 1'b1;
					end
				end
			end
			ST_ENC: begin
				out_load  = slot_free;
				enc_shift = slot_free;
				out_byte  = {enc_more, enc_q[GROUP_W-1:0]};
				out_last  = !enc_more;
			end
			ST_ERR: begin
				out_load  = slot_free;
				out_kind  = KIND_VALUE;
				out_error = 1'b1;
				out_last  = 1'b1;
			end
			ST_ALIGN: begin
				out_kind  = KIND_VALUE;
				out_last  = 1'b1;
				out_value = dec_value;
				if (!dec_stat.done) begin
					dec_ctrl.align = 1'b1;
				end else begin
					out_load       = slot_free;
					dec_ctrl.clear = slot_free;
				end
			end
			default: begin
			end
		endcase
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {out_value, out_byte};
			m_tuser_q <= {out_error, out_kind};
			m_tlast_q <= out_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

`ifndef NO_ASSERTIONS
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> dec_stat.count < LIMIT_WIDE)
		else $error("decode byte count reached the limit while idle");

	a_error_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast && m_tuser[0] == KIND_VALUE && m_tdata == '0)
		else $error("error result is not a final empty value");

	a_enc_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] == KIND_BYTE |-> m_tlast == !m_tdata[BYTE_W-1])
		else $error("encoded byte continuation disagrees with last");

	a_value_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && out_kind == KIND_VALUE && !out_error |-> dec_stat.done)
		else $error("decoded value loaded before alignment finished");
`endif

endmodule

>>> hdl/vc_dec.sv
// vc_dec: decode accumulator, a 70-bit shift line fed one 7-bit group per word
// groups enter at the top and are aligned by further zero shifts; uses vc_pkg
module vc_dec (
	input  logic                     clk,
	input  logic                     arst_n,
	input  vc_pkg::dec_ctrl_t        ctrl,
	input  logic [vc_pkg::GROUP_W-1:0] group_in,
	input  logic                     wide_mode,
	output vc_pkg::dec_stat_t        stat,
	output logic [vc_pkg::VALUE_W-1:0] value
);
	import vc_pkg::*;

	logic [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0] shift_q;

	// group shift line: new group at the top, zeros while aligning
	always_ff @(posedge clk) begin
		if (ctrl.take) begin
			acc_q <= {group_in, acc_q[ACC_W-1:GROUP_W]};
		end else if (ctrl.align) begin
			acc_q <= {{GROUP_W{1'b0}}, acc_q[ACC_W-1:GROUP_W]};
		end else if (ctrl.clear) begin
			acc_q <= '0;
		end
	end

	// shifts done so far; equals the byte count until alignment starts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
		end else if (ctrl.clear) begin
			shift_q <= '0;
		end else if (ctrl.take || ctrl.align) begin
			shift_q <= shift_q + 4'd1;
		end
	end

	// status and width-masked result
	assign stat.count = shift_q;
	assign stat.done  = (shift_q == GROUPS_MAX);
	assign value = wide_mode ? acc_q[VALUE_W-1:0]
	                         : {{(VALUE_W-NARROW_W){1'b0}}, acc_q[NARROW_W-1:0]};

`ifndef NO_ASSERTIONS
	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		shift_q <= GROUPS_MAX)
		else $error("decode shift count beyond ten groups");
`endif

endmodule

>>> tb/varint_codec_checker.sv
// varint_codec_checker: watches the cfg, command and result channels of varint_codec,
// predicts every result word and compares it field by field
// depends on vc_pkg for widths, limits and the command and kind codes
module varint_codec_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [71:0] s_tdata,       // value[63:0], in_byte[71:64]
	input  logic        s_tuser,       // cmd
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,       // out_byte[7:0], out_value[71:8]
	input  logic [1:0]  m_tuser,       // kind[0], error[1]
	input  logic        m_tlast,
	output int          pending,
	output int          failures,
	output int          n_values,
	output int          n_overruns
);
	timeunit 1ns;
	timeprecision 1ps;
	import vc_pkg::*;

	typedef struct packed {
		logic               kind;
		logic [BYTE_W-1:0]  code;
		logic [VALUE_W-1:0] value;
		logic               last;
		logic               err;
	} result_t;

	result_t            result_q[$];
	logic               wide_mode = 1'b0;
	logic [VALUE_W-1:0] acc = '0;
	logic [CNT_W-1:0]   taken = '0;

	initial begin
		pending    = 0;
		failures   = 0;
		n_values   = 0;
		n_overruns = 0;
	end

	function automatic logic [VALUE_W-1:0] value_mask();
		return wide_mode ? '1 : {{(VALUE_W-NARROW_W){1'b0}}, {NARROW_W{1'b1}}};
	endfunction

	// split a value into groups, low group first, bit 7 marks more to come
	task automatic expect_encoding(input logic [VALUE_W-1:0] v);
		logic [VALUE_W-1:0] rest;
		result_t            r;
		logic               more;
		rest = v & value_mask();
		for (int n = 0; n < GROUPS_MAX; n++) begin
			r.kind  = KIND_BYTE;
			r.code  = {1'b0, rest[GROUP_W-1:0]};
			rest    = rest >> GROUP_W;
			more    = (rest != 0);
			r.code[BYTE_W-1] = more;
			r.value = '0;
			r.last  = !more;
			r.err   = 1'b0;
			result_q.push_back(r);
			if (!more)
				break;
		end
	endtask

	// gather one stream byte; close on a clear bit 7 or fail at the byte limit
	task automatic expect_decoding(input logic [BYTE_W-1:0] b);
		logic [CNT_W-1:0]   limit;
		logic [CNT_W-1:0]   pos;
		logic [VALUE_W-1:0] grp;
		result_t            r;
		limit = wide_mode ? LIMIT_WIDE : LIMIT_NARROW;
		pos   = (taken > 4'd9) ? 4'd9 : taken;
		grp   = {{(VALUE_W-GROUP_W){1'b0}}, b[GROUP_W-1:0]};
		acc   = (acc | (grp << (pos * GROUP_W))) & value_mask();
		r.kind = KIND_VALUE;
		r.code = '0;
		r.last = 1'b1;
		if (!b[BYTE_W-1]) begin
			r.value = acc;
			r.err   = 1'b0;
			result_q.push_back(r);
			acc   = '0;
			taken = '0;
		end else begin
			pos = pos + 4'd1;
			if (pos >= limit) begin
				r.value = '0;
				r.err   = 1'b1;
				result_q.push_back(r);
				acc   = '0;
				taken = '0;
			end else begin
				taken = pos;
			end
		end
	endtask

	// compare one result word against the oldest expectation
	task automatic check_word(input result_t got);
		result_t want;
		if (result_q.size() == 0) begin
			$error("result word with nothing expected: kind %0d byte %02h value %016h",
				got.kind, got.code, got.value);
			failures++;
			return;
		end
		want = result_q.pop_front();
		if (got.kind != want.kind) begin
			$error("kind: expected %0d, got %0d", want.kind, got.kind);
			failures++;
		end
		if (got.code != want.code) begin
			$error("out_byte: expected %02h, got %02h", want.code, got.code);
			failures++;
		end
		if (got.value != want.value) begin
			$error("out_value: expected %016h, got %016h", want.value, got.value);
			failures++;
		end
		if (got.last != want.last) begin
			$error("last: expected %0d, got %0d", want.last, got.last);
			failures++;
		end
		if (got.err != want.err) begin
			$error("error: expected %0d, got %0d", want.err, got.err);
			failures++;
		end
		if (want.kind == KIND_VALUE && !want.err)
			n_values++;
		if (want.err)
			n_overruns++;
	endtask

	// mode writes first, then new commands, then results leaving the block
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_mode = 1'b0;
			acc       = '0;
			taken     = '0;
			result_q.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				wide_mode = cfg_data;
			if (s_tvalid && s_tready) begin
				if (s_tuser == CMD_ENCODE)
					expect_encoding(s_tdata[63:0]);
				else
					expect_decoding(s_tdata[71:64]);
			end
			if (m_tvalid && m_tready)
				check_word('{kind: m_tuser[0], code: m_tdata[7:0], value: m_tdata[71:8],
					last: m_tlast, err: m_tuser[1]});
		end
		pending = result_q.size();
	end

endmodule

>>> tb/tb_varint_codec.sv
// tb_varint_codec: stimulus and verdict for varint_codec, directed words then random
// encodes and decode streams in both width modes; uses vc_pkg and varint_codec_checker
module tb_varint_codec;
	timeunit 1ns;
	timeprecision 1ps;
	import vc_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	int pending;
	int failures;
	int n_values;
	int n_overruns;
	int n_enc = 0;
	int n_dec = 0;
	int n_mode_writes = 0;
	logic steady = 1'b1;

	varint_codec DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	varint_codec_checker u_check (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop well past the slowest correct run
	initial begin
		#4_000_000;
		$display("timeout with %0d result words still expected", pending);
		$display("[varint_codec] ERROR");
		$finish;
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// random value of random bit length
	function automatic logic [63:0] rand_value();
		logic [63:0] v;
		int          len;
		v   = {$urandom, $urandom};
		len = $urandom_range(0, 64);
		if (len < 64)
			v = v & ((64'd1 << len) - 64'd1);
		return v;
	endfunction

	// receiver stalls
	initial begin
		int stall;
		stall    = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				m_tready = 1'b0;
				stall--;
			end else begin
				m_tready = 1'b1;
				if (!steady && $urandom_range(0, 3) == 0)
					stall = pick_gap();
			end
		end
	end

	// one command word, called and returning at a falling edge
	task automatic put_word(input logic cmd, input logic [63:0] val, input logic [7:0] b);
		int gap;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = cmd;
		s_tdata  = {b, val};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic encode_word(input logic [63:0] val);
		put_word(CMD_ENCODE, val, 8'($urandom));
		n_enc++;
	endtask

	task automatic decode_word(input logic [7:0] b);
		put_word(CMD_DECODE, {$urandom, $urandom}, b);
		n_dec++;
	endtask

	// wait for every expected word, then let a pending decode settle
	task automatic drain();
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// width mode write, only with the block idle
	task automatic set_mode(input logic wide);
		drain();
		cfg_valid = 1'b1;
		cfg_data  = wide;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
		n_mode_writes++;
	endtask

	initial begin
		logic        wide;
		logic [7:0]  b;
		int          target;
		int          k;
		int          lim;
		int          pick;

		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = CMD_ENCODE;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed, narrow mode: value extremes, group boundary, width overflow
		set_mode(1'b0);
		encode_word(64'd0);
		encode_word('1);
		encode_word(64'd128);
		decode_word(8'h7F);
		repeat (4) decode_word(8'hFF);
		decode_word(8'h7F);
		// byte limit with continuation still set
		repeat (5) decode_word(8'h80);
		// encode in the middle of a decode leaves the decoder alone
		decode_word(8'h81);
		encode_word(64'd1);
		decode_word(8'h01);

		// directed, wide mode: full ten-byte encoding, then a mode drop mid-stream
		set_mode(1'b1);
		encode_word('1);
		repeat (6) decode_word(8'h80);
		set_mode(1'b0);
		decode_word(8'h80);

		// random phases alternating the width mode
		wide   = 1'b0;
		target = n_enc + n_dec + 205;
		while (n_enc + n_dec < target) begin
			wide = ~wide;
			set_mode(wide);
			lim    = wide ? 10 : 5;
			steady = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(10, 30)) begin
				if (n_enc + n_dec >= target)
					break;
				if ($urandom_range(0, 29) == 0)
					drain();
				pick = $urandom_range(0, 99);
				if (pick < 35) begin
					encode_word(($urandom_range(0, 4) == 0) ? {$urandom, $urandom} : rand_value());
				end else if (pick < 80) begin
					// well-formed stream with random groups, now and then an encode inside
					k = $urandom_range(1, lim);
					for (int i = 0; i < k; i++) begin
						b    = 8'($urandom);
						b[7] = (i < k - 1);
						if ($urandom_range(0, 19) == 0)
							encode_word(rand_value());
						decode_word(b);
					end
				end else if (pick < 92) begin
					// overlong stream runs into the byte limit
					for (int i = 0; i < lim; i++) begin
						b    = 8'($urandom);
						b[7] = 1'b1;
						decode_word(b);
					end
				end else begin
					decode_word(8'($urandom));
				end
			end
		end

		steady = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);

		$display("covered %0d encode and %0d decode words over %0d width mode writes",
			n_enc, n_dec, n_mode_writes);
		$display("checked %0d decoded values and %0d byte-limit overruns", n_values, n_overruns);
		if (failures == 0)
			$display("[varint_codec] OK");
		else
			$display("[varint_codec] ERROR");
		$finish;
	end

endmodule

>>> sim.f
hdl/vc_pkg.sv
hdl/vc_dec.sv
hdl/varint_codec.sv
tb/varint_codec_checker.sv
tb/tb_varint_codec.sv
